// ===== hdl/spa_pkg.sv =====
// shared types, constants and reset values for the search and pid align block
package spa_pkg;

  localparam int unsigned FrameWidthPx = 640;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  typedef enum logic [1:0] {
    MODE_SEARCH = 2'd0,
    MODE_ALIGN  = 2'd1,
    MODE_DONE   = 2'd2,
    MODE_FAIL   = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_CLASS    = 3'd0,
    CFG_SEARCH_RATE     = 3'd1,
    CFG_ALIGN_THRESHOLD = 3'd2,
    CFG_GAIN_P          = 3'd3,
    CFG_GAIN_I_TICK     = 3'd4,
    CFG_GAIN_D_TICK     = 3'd5,
    CFG_OUTPUT_LIMIT    = 3'd6,
    CFG_SEARCH_TIMEOUT  = 3'd7
  } cfg_idx_e;

  localparam logic [7:0]         RstTargetClass    = 8'd0;
  localparam logic signed [15:0] RstSearchRate     = 16'sd1638;
  localparam logic [9:0]         RstAlignThreshold = 10'd7;
  localparam logic [19:0]        RstGainP          = 20'd83886;
  localparam logic [19:0]        RstGainITick      = 20'd524;
  localparam logic [19:0]        RstGainDTick      = 20'd419430;
  localparam logic [14:0]        RstOutputLimit    = 15'd2048;
  localparam logic [15:0]        RstSearchTimeout  = 16'd600;

  // one frame-end request handed to the pid datapath
  typedef struct packed {
    logic               is_pid;
    logic signed [15:0] fixed_rate;
    logic [1:0]         status;
    logic [9:0]         held_x;
    logic [9:0]         held_w;
    logic signed [10:0] err;
    logic signed [23:0] esum;
    logic signed [11:0] derr;
  } pid_req_t;

  typedef struct packed {
    logic [19:0] gain_p;
    logic [19:0] gain_i;
    logic [19:0] gain_d;
    logic [14:0] limit;
  } pid_cfg_t;

endpackage

// ===== hdl/search_and_pid_align.sv =====
// target search and pid turn alignment, top level
//
//   channel   | signals                                   | moves
//   ----------+-------------------------------------------+-------------------------
//   in        | in_valid_i / in_ready_o                   | one detection request
//   out       | out_valid_o / out_ready_i                 | one turn-rate command
//   cfg       | cfg_we_i, cfg_idx_i, cfg_data_i           | register write, no wait
//
// one request accepted per cycle while in_ready_o is high; frame and pid state settle at the accept edge
// a frame_end request has its command on the output after passing, in order, the
// request register, the product register and the output register
// other requests give no command; reset clears mode, counters and the held box
// a stalled output holds its command; three commands wait, then the input stalls
module search_and_pid_align #(
  parameter int unsigned FrameWidth = spa_pkg::FrameWidthPx
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [spa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [spa_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         has_detection_i,
  input  logic [7:0]                   class_id_i,
  input  logic [9:0]                   box_x_i,
  input  logic [9:0]                   box_w_i,
  input  logic                         frame_end_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [15:0]                  turn_rate_o,
  output logic [1:0]                   status_o,
  output logic [9:0]                   matched_x_o,
  output logic [9:0]                   matched_w_o
);

  localparam logic signed [12:0] HalfW = 13'(FrameWidth / 2);

  // configuration
  logic [7:0]         target_class_q;
  logic signed [15:0] search_rate_q;
  logic [9:0]         align_threshold_q;
  logic [19:0]        gain_p_q, gain_i_q, gain_d_q;
  logic [14:0]        output_limit_q;
  logic [15:0]        search_timeout_q;

  // frame state
  spa_pkg::mode_e     mode_q, mode_d;
  logic [15:0]        ticks_q, ticks_d;
  logic signed [23:0] esum_q, esum_d;
  logic signed [10:0] last_err_q, last_err_d;
  logic               matched_q, matched_d;
  logic [9:0]         held_x_q, held_x_d, held_w_q, held_w_d;

  logic               s1_v_q;
  spa_pkg::pid_req_t  s1_q, s1_d;
  spa_pkg::pid_cfg_t  pid_cfg;
  logic               pid_ready;
  logic               accept;

  logic               match_now, matched;
  logic signed [12:0] diff;
  logic signed [10:0] err;
  logic [10:0]        mag;
  logic               aligned;
  logic signed [23:0] base_sum;
  logic signed [10:0] base_last;
  logic signed [24:0] sum25;
  logic signed [23:0] esum_new;

  assign in_ready_o = !s1_v_q || pid_ready;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_class_q    <= spa_pkg::RstTargetClass;
      search_rate_q     <= spa_pkg::RstSearchRate;
      align_threshold_q <= spa_pkg::RstAlignThreshold;
      gain_p_q          <= spa_pkg::RstGainP;
      gain_i_q          <= spa_pkg::RstGainITick;
      gain_d_q          <= spa_pkg::RstGainDTick;
      output_limit_q    <= spa_pkg::RstOutputLimit;
      search_timeout_q  <= spa_pkg::RstSearchTimeout;
    end else if (cfg_we_i) begin
      case (spa_pkg::cfg_idx_e'(cfg_idx_i))
        spa_pkg::CFG_TARGET_CLASS:    target_class_q    <= cfg_data_i[7:0];
        spa_pkg::CFG_SEARCH_RATE:     search_rate_q     <= cfg_data_i[15:0];
        spa_pkg::CFG_ALIGN_THRESHOLD: align_threshold_q <= cfg_data_i[9:0];
        spa_pkg::CFG_GAIN_P:          gain_p_q          <= cfg_data_i[19:0];
        spa_pkg::CFG_GAIN_I_TICK:     gain_i_q          <= cfg_data_i[19:0];
        spa_pkg::CFG_GAIN_D_TICK:     gain_d_q          <= cfg_data_i[19:0];
        spa_pkg::CFG_OUTPUT_LIMIT:    output_limit_q    <= cfg_data_i[14:0];
        spa_pkg::CFG_SEARCH_TIMEOUT:  search_timeout_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    match_now = (mode_q == spa_pkg::MODE_SEARCH || mode_q == spa_pkg::MODE_ALIGN)
                && has_detection_i && (class_id_i == target_class_q) && !matched_q;
    matched   = matched_q || match_now;
    held_x_d  = match_now ? box_x_i : held_x_q;
    held_w_d  = match_now ? box_w_i : held_w_q;

    // pixel error of the box centre
    diff = HalfW - $signed({3'b000, held_x_d}) - $signed({4'b0000, held_w_d[9:1]});
    if (diff > 13'sd1023) begin
      err = 11'sd1023;
    end else if (diff < -13'sd1024) begin
      err = -11'sd1024;
    end else begin
      err = diff[10:0];
    end
    mag     = err[10] ? (~err + 11'd1) : err;
    aligned = mag < {1'b0, align_threshold_q};

    base_sum  = (mode_q == spa_pkg::MODE_SEARCH) ? 24'sd0 : esum_q;
    base_last = (mode_q == spa_pkg::MODE_SEARCH) ? 11'sd0 : last_err_q;
    sum25     = {base_sum[23], base_sum} + 25'(err);
    if (sum25 > 25'sd8388607) begin
      esum_new = 24'sd8388607;
    end else if (sum25 < -25'sd8388608) begin
      esum_new = -24'sd8388608;
    end else begin
      esum_new = sum25[23:0];
    end

    mode_d     = mode_q;
    ticks_d    = ticks_q;
    esum_d     = esum_q;
    last_err_d = last_err_q;
    matched_d  = frame_end_i ? 1'b0 : matched;

    s1_d            = '0;
    s1_d.fixed_rate = 16'sd0;
    s1_d.held_x     = held_x_d;
    s1_d.held_w     = held_w_d;
    s1_d.err        = err;
    s1_d.esum       = esum_new;
    s1_d.derr       = 12'(err) - 12'(base_last);

    if ((mode_q == spa_pkg::MODE_SEARCH || mode_q == spa_pkg::MODE_ALIGN) && matched) begin
      esum_d     = base_sum;
      last_err_d = base_last;
      if (aligned) begin
        mode_d = spa_pkg::MODE_DONE;
      end else begin
        mode_d      = spa_pkg::MODE_ALIGN;
        esum_d      = esum_new;
        last_err_d  = err;
        s1_d.is_pid = 1'b1;
      end
    end else if (mode_q == spa_pkg::MODE_SEARCH) begin
      if (ticks_q >= search_timeout_q) begin
        mode_d = spa_pkg::MODE_FAIL;
      end else begin
        ticks_d         = ticks_q + 16'd1;
        s1_d.fixed_rate = search_rate_q;
      end
    end else if (mode_q == spa_pkg::MODE_ALIGN) begin
      mode_d          = spa_pkg::MODE_SEARCH;
      ticks_d         = 16'd0;
      s1_d.fixed_rate = search_rate_q;
    end
    s1_d.status = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= spa_pkg::MODE_SEARCH;
      ticks_q    <= '0;
      esum_q     <= '0;
      last_err_q <= '0;
      matched_q  <= 1'b0;
      held_x_q   <= '0;
      held_w_q   <= '0;
      s1_v_q     <= 1'b0;
    end else begin
      if (accept) begin
        matched_q <= matched_d;
        held_x_q  <= held_x_d;
        held_w_q  <= held_w_d;
        if (frame_end_i) begin
          mode_q     <= mode_d;
          ticks_q    <= ticks_d;
          esum_q     <= esum_d;
          last_err_q <= last_err_d;
        end
      end
      if (in_ready_o) begin
        s1_v_q <= accept && frame_end_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && frame_end_i) begin
      s1_q <= s1_d;
    end
  end

  assign pid_cfg.gain_p = gain_p_q;
  assign pid_cfg.gain_i = gain_i_q;
  assign pid_cfg.gain_d = gain_d_q;
  assign pid_cfg.limit  = output_limit_q;

  spa_pid u_pid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s1_v_q),
    .req_ready_o (pid_ready),
    .req_i       (s1_q),
    .cfg_i       (pid_cfg),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .turn_rate_o (turn_rate_o),
    .status_o    (status_o),
    .matched_x_o (matched_x_o),
    .matched_w_o (matched_w_o)
  );

endmodule

// ===== hdl/spa_pid.sv =====
// pid datapath: registered products, then sum, rounding and output clamp; non-pid requests pass their fixed rate
module spa_pid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  spa_pkg::pid_req_t req_i,
  input  spa_pkg::pid_cfg_t cfg_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       turn_rate_o,
  output logic [1:0]        status_o,
  output logic [9:0]        matched_x_o,
  output logic [9:0]        matched_w_o
);

  logic               s2_v_q;
  logic signed [31:0] prod_p_q;
  logic signed [44:0] prod_i_q;
  logic signed [32:0] prod_d_q;
  logic               is_pid_q;
  logic signed [15:0] fixed_rate_q;
  logic [1:0]         status_q;
  logic [9:0]         x_q, w_q;

  logic               out_v_q;
  logic [15:0]        rate_q;
  logic [1:0]         out_status_q;
  logic [9:0]         out_x_q, out_w_q;

  logic               out_rdy, s2_rdy;
  logic signed [46:0] sum_d;
  logic signed [38:0] quot;
  logic signed [38:0] lim_pos, lim_neg;
  logic signed [15:0] clamped;

  assign out_rdy     = !out_v_q || out_ready_i;
  assign s2_rdy      = !s2_v_q || out_rdy;
  assign req_ready_o = s2_rdy;

  // products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= req_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && req_valid_i) begin
      prod_p_q     <= $signed({1'b0, cfg_i.gain_p}) * $signed(req_i.err);
      prod_i_q     <= $signed({1'b0, cfg_i.gain_i}) * $signed(req_i.esum);
      prod_d_q     <= $signed({1'b0, cfg_i.gain_d}) * $signed(req_i.derr);
      is_pid_q     <= req_i.is_pid;
      fixed_rate_q <= req_i.fixed_rate;
      status_q     <= req_i.status;
      x_q          <= req_i.held_x;
      w_q          <= req_i.held_w;
    end
  end

  // sum, round half up, clamp
  always_comb begin
    sum_d   = 47'(prod_p_q) + 47'(prod_i_q) + 47'(prod_d_q) + 47'sd128;
    quot    = sum_d[46:8];
    lim_pos = $signed({24'd0, cfg_i.limit});
    lim_neg = -lim_pos;
    if (quot > lim_pos) begin
      clamped = lim_pos[15:0];
    end else if (quot < lim_neg) begin
      clamped = lim_neg[15:0];
    end else begin
      clamped = quot[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && s2_v_q) begin
      rate_q       <= is_pid_q ? clamped : fixed_rate_q;
      out_status_q <= status_q;
      out_x_q      <= x_q;
      out_w_q      <= w_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign turn_rate_o = rate_q;
  assign status_o    = out_status_q;
  assign matched_x_o = out_x_q;
  assign matched_w_o = out_w_q;

endmodule
